// File: hdl/oqr_pkg.sv
`timescale 1ns / 1ps

package oqr_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int ID_BITS_DEF  = 16;

    localparam int ITEM_ID_W = 16;
    localparam int STATUS_W  = 3;
    localparam int OCC_W     = 5;

    typedef enum logic
    {
        REQ_ADD    = 1'b0,
        REQ_REMOVE = 1'b1
    } req_type_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_ADDED     = 3'd0,
        ST_REMOVED   = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_CMP,
        S_SHIFT
    } state_t;

    typedef struct packed
    {
        req_type_t              req_type;
        logic [ITEM_ID_W-1:0]   item_id;
    } in_item_t;

    typedef struct packed
    {
        status_t                status;
        logic [OCC_W-1:0]       occupancy;
    } out_item_t;

endpackage

// File: hdl/ordered_queue_remove_by_id.sv
`timescale 1ns / 1ps

// Insertion-ordered queue of identifiers with room for CAPACITY entries. A transaction is
// accepted when start is high and busy is low, and exactly one result follows as a
// single-cycle pulse on done; the receiver cannot stall, so result must be captured in
// that cycle. An add, or a remove on an empty queue, gives its result in the cycle after
// acceptance. A remove walks the queue from the head one entry per cycle through the single
// read port of the entry memory and one comparator, then closes the gap one entry per cycle
// through the same port. Busy falls in the cycle that done is high, so a new transaction
// may be accepted in that cycle.
module ordered_queue_remove_by_id #(
    parameter int CAPACITY = oqr_pkg::CAPACITY_DEF,
    parameter int ID_BITS  = oqr_pkg::ID_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  oqr_pkg::in_item_t  req,
    output logic               done,
    output oqr_pkg::out_item_t result
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    oqr_pkg::state_t    state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      ptr_reg, ptr_next;
    logic [ID_BITS-1:0] key_reg, key_next;
    logic               done_reg, done_next;
    oqr_pkg::out_item_t result_reg, result_next;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [ID_BITS-1:0] wr_data;
    logic [AW-1:0]      rd_addr;
    logic [ID_BITS-1:0] rd_data;

    logic [CW-1:0]      ptr_ext;
    logic [CW-1:0]      ptr_p1;
    logic [CW-1:0]      ptr_p2;
    logic [ID_BITS-1:0] in_key;
    logic               hit;

    assign ptr_ext = CW'(ptr_reg);
    assign ptr_p1  = ptr_ext + CW'(1);
    assign ptr_p2  = ptr_ext + CW'(2);
    assign in_key  = ID_BITS'(req.item_id);
    assign hit     = (rd_data == key_reg);

    oqr_store #(
        .DEPTH (CAPACITY),
        .WIDTH (ID_BITS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= oqr_pkg::S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        key_reg    <= key_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        key_next    = key_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        wr_en       = 1'b0;
        wr_addr     = ptr_reg;
        wr_data     = rd_data;
        rd_addr     = '0;

        unique case (state_reg)
            oqr_pkg::S_IDLE:
            begin
                if (start)
                begin
                    key_next = in_key;
                    ptr_next = '0;
                    if (req.req_type == oqr_pkg::REQ_ADD)
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            result_next.status = oqr_pkg::ST_FULL;
                        end
                        else
                        begin
                            wr_en              = 1'b1;
                            wr_addr            = count_reg[AW-1:0];
                            wr_data            = in_key;
                            count_next         = count_reg + CW'(1);
                            result_next.status = oqr_pkg::ST_ADDED;
                        end
                        done_next = 1'b1;
                    end
                    else if (count_reg == '0)
                    begin
                        result_next.status = oqr_pkg::ST_EMPTY;
                        done_next          = 1'b1;
                    end
                    else
                    begin
                        state_next = oqr_pkg::S_CMP;
                    end
                end
            end

            oqr_pkg::S_CMP:
            begin
                rd_addr = ptr_p1[AW-1:0];
                if (hit)
                begin
                    if (ptr_p1 >= count_reg)
                    begin
                        count_next         = count_reg - CW'(1);
                        result_next.status = oqr_pkg::ST_REMOVED;
                        done_next          = 1'b1;
                        state_next         = oqr_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = oqr_pkg::S_SHIFT;
                    end
                end
                else if (ptr_p1 >= count_reg)
                begin
                    result_next.status = oqr_pkg::ST_NOT_FOUND;
                    done_next          = 1'b1;
                    state_next         = oqr_pkg::S_IDLE;
                end
                else
                begin
                    ptr_next = ptr_p1[AW-1:0];
                end
            end

            oqr_pkg::S_SHIFT:
            begin
                wr_en    = 1'b1;
                wr_addr  = ptr_reg;
                wr_data  = rd_data;
                rd_addr  = ptr_p2[AW-1:0];
                ptr_next = ptr_p1[AW-1:0];
                if (ptr_p2 >= count_reg)
                begin
                    count_next         = count_reg - CW'(1);
                    result_next.status = oqr_pkg::ST_REMOVED;
                    done_next          = 1'b1;
                    state_next         = oqr_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = oqr_pkg::S_IDLE;
            end
        endcase

        result_next.occupancy = oqr_pkg::OCC_W'(count_next);
    end

    assign busy   = (state_reg != oqr_pkg::S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: hdl/oqr_store.sv
`timescale 1ns / 1ps

module oqr_store #(
    parameter int DEPTH = oqr_pkg::CAPACITY_DEF,
    parameter int WIDTH = oqr_pkg::ID_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule
